// File: sv/cid_pkg.sv
// ----------------------------------------------------------------------------
// cid_pkg
// Shared types and constants of the character image cross dilation unit.
// ----------------------------------------------------------------------------
package cid_pkg;

  localparam int PIX_W      = 8;
  localparam int FW_W       = 11;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 11;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MODE    = 2'd0,
    CFG_TARGET  = 2'd1,
    CFG_REPLACE = 2'd2,
    CFG_WIDTH   = 2'd3
  } cfg_idx_t;

  localparam logic            RST_MODE    = 1'b0;
  localparam logic [PIX_W-1:0] RST_TARGET  = 8'd35;
  localparam logic [PIX_W-1:0] RST_REPLACE = 8'd46;
  localparam logic [FW_W-1:0]  RST_WIDTH   = 11'd1024;

  localparam logic MODE_GROW    = 1'b0;
  localparam logic MODE_REPLACE = 1'b1;

  localparam logic OP_PIXEL = 1'b0;
  localparam logic OP_FLUSH = 1'b1;

  // Number of image rows held in the line stores.
  localparam logic [1:0] ROWS_NONE = 2'd0;
  localparam logic [1:0] ROWS_MID  = 2'd1;
  localparam logic [1:0] ROWS_BOTH = 2'd2;

  typedef struct packed {
    logic             op;
    logic [PIX_W-1:0] pixel;
  } cid_in_t;

  typedef struct packed {
    logic [PIX_W-1:0] pixel_out;
    logic             end_of_frame;
  } cid_out_t;

  typedef struct packed {
    logic             op;
    logic [PIX_W-1:0] pixel;
    logic             last;
    logic [1:0]       rows;
    logic             left_ok;
    logic             right_ok;
  } cid_s1_t;

  typedef struct packed {
    logic [PIX_W-1:0] center;
    logic [PIX_W-1:0] right;
    logic [PIX_W-1:0] up;
  } cid_nbr_t;

  typedef struct packed {
    logic             we;
    logic [PIX_W-1:0] mid;
    logic [PIX_W-1:0] up;
  } cid_wr_t;

endpackage

// File: sv/cid_scan.sv
// ----------------------------------------------------------------------------
// cid_scan
// Raster position tracking, line store read requests and the stage register
// that holds a transaction while its neighbours are read.
// ----------------------------------------------------------------------------
module cid_scan import cid_pkg::*; #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  cid_in_t                       in_data,
  input  logic [FW_W-1:0]               frame_width,
  input  logic                          s1_go,
  output logic                          rd_en,
  output logic [$clog2(MAX_WIDTH)-1:0]  rd_col,
  output logic [$clog2(MAX_WIDTH)-1:0]  rd_next,
  output logic                          s1_valid,
  output cid_s1_t                       s1_info,
  output logic [$clog2(MAX_WIDTH)-1:0]  s1_col
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int LW = (FW_W > CW + 1) ? FW_W : CW + 1;

  logic [CW-1:0] col_r, col_nxt;
  logic [1:0]    rows_r, rows_nxt;
  logic          s1_valid_r;
  cid_s1_t       s1_info_r;
  logic [CW-1:0] s1_col_r;
  logic [LW-1:0] w_eff;
  logic          last;
  logic          accept;

  always_comb begin
    if (frame_width == '0) begin
      w_eff = LW'(1);
    end else if (LW'(frame_width) > LW'(MAX_WIDTH)) begin
      w_eff = LW'(MAX_WIDTH);
    end else begin
      w_eff = LW'(frame_width);
    end
  end

  // A column at or past the width in use also closes the row.
  assign last     = (LW'(col_r) + LW'(1)) >= w_eff;
  assign in_ready = !s1_valid_r || s1_go;
  assign accept   = in_valid && in_ready;

  always_comb begin
    col_nxt  = col_r;
    rows_nxt = rows_r;
    if (accept) begin
      if (last) begin
        col_nxt = '0;
        if (in_data.op == OP_FLUSH) begin
          rows_nxt = ROWS_NONE;
        end else if (rows_r != ROWS_BOTH) begin
          rows_nxt = rows_r + 2'd1;
        end
      end else begin
        col_nxt = col_r + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r      <= '0;
      rows_r     <= ROWS_NONE;
      s1_valid_r <= 1'b0;
    end else begin
      col_r  <= col_nxt;
      rows_r <= rows_nxt;
      if (accept) begin
        s1_valid_r <= 1'b1;
      end else if (s1_go) begin
        s1_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_info_r <= '{op:       in_data.op,
                     pixel:    in_data.pixel,
                     last:     last,
                     rows:     rows_r,
                     left_ok:  (col_r != '0),
                     right_ok: !last};
      s1_col_r  <= col_r;
    end
  end

  assign rd_en    = accept;
  assign rd_col   = col_r;
  assign rd_next  = col_r + CW'(1);
  assign s1_valid = s1_valid_r;
  assign s1_info  = s1_info_r;
  assign s1_col   = s1_col_r;

endmodule

// File: sv/cid_line_store.sv
// ----------------------------------------------------------------------------
// cid_line_store
// Upper and middle row memories with registered reads, and forwarding
// of the write that lands in the same cycle as a read of the same column.
// ----------------------------------------------------------------------------
module cid_line_store import cid_pkg::*; #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                          clk,
  input  logic                          rd_en,
  input  logic [$clog2(MAX_WIDTH)-1:0]  rd_col,
  input  logic [$clog2(MAX_WIDTH)-1:0]  rd_next,
  input  cid_wr_t                       wr,
  input  logic [$clog2(MAX_WIDTH)-1:0]  wr_col,
  output cid_nbr_t                      nbr
);

  logic [PIX_W-1:0] mid_mem [MAX_WIDTH];
  logic [PIX_W-1:0] up_mem  [MAX_WIDTH];

  logic [PIX_W-1:0] mid_c_r, mid_n_r, up_rd_r;
  logic [PIX_W-1:0] fwd_mid_r, fwd_up_r;
  logic             hit_c_r, hit_n_r;

  // The memories return the old contents on a same-address write, so the
  // value being written is captured alongside the read and preferred.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      mid_c_r   <= mid_mem[rd_col];
      mid_n_r   <= mid_mem[rd_next];
      up_rd_r   <= up_mem[rd_col];
      hit_c_r   <= wr.we && (wr_col == rd_col);
      hit_n_r   <= wr.we && (wr_col == rd_next);
      fwd_mid_r <= wr.mid;
      fwd_up_r  <= wr.up;
    end
    if (wr.we) begin
      mid_mem[wr_col] <= wr.mid;
      up_mem[wr_col]  <= wr.up;
    end
  end

  assign nbr.center = hit_c_r ? fwd_mid_r : mid_c_r;
  assign nbr.right  = hit_n_r ? fwd_mid_r : mid_n_r;
  assign nbr.up     = hit_c_r ? fwd_up_r  : up_rd_r;

endmodule

// File: sv/cid_eval.sv
// ----------------------------------------------------------------------------
// cid_eval
// Grow or replace decision for one pixel, line store write-back and the
// output register.
// ----------------------------------------------------------------------------
module cid_eval import cid_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             s1_valid,
  input  cid_s1_t          s1_info,
  input  cid_nbr_t         nbr,
  input  logic             mode,
  input  logic [PIX_W-1:0] target_char,
  input  logic [PIX_W-1:0] replace_char,
  input  logic             out_ready,
  output logic             s1_go,
  output cid_wr_t          wr,
  output logic             out_valid,
  output cid_out_t         out_data
);

  logic [PIX_W-1:0] left_r;
  logic             out_valid_r;
  cid_out_t         out_data_r;
  logic             emit;
  logic             hit;
  logic             advance;
  logic [PIX_W-1:0] res;

  assign emit = (s1_info.rows != ROWS_NONE);

  assign hit = ((s1_info.rows == ROWS_BOTH) && (nbr.up == target_char))
            || ((s1_info.op == OP_PIXEL) && (s1_info.pixel == target_char))
            || (s1_info.left_ok && (left_r == target_char))
            || (s1_info.right_ok && (nbr.right == target_char));

  always_comb begin
    res = nbr.center;
    if (mode == MODE_REPLACE) begin
      if (nbr.center == target_char) begin
        res = replace_char;
      end
    end else if ((nbr.center != target_char) && hit) begin
      res = target_char;
    end
  end

  assign s1_go   = !emit || !out_valid_r || out_ready;
  assign advance = s1_valid && s1_go;
  assign wr      = '{we: advance, mid: s1_info.pixel, up: nbr.center};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance && emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // The left neighbour is the middle-row pixel of the previous column, taken
  // before this row overwrote it.
  always_ff @(posedge clk) begin
    if (advance) begin
      left_r <= nbr.center;
    end
    if (advance && emit) begin
      out_data_r <= '{pixel_out:    res,
                      end_of_frame: (s1_info.op == OP_FLUSH) && s1_info.last};
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// File: sv/char_image_cross_dilation_unit.sv
// ----------------------------------------------------------------------------
// char_image_cross_dilation_unit
// Streaming four-neighbour grow and replace on a character image.
// ----------------------------------------------------------------------------
// Pixels enter in raster order, one per clock, and each comes back one image
// row later, when the pixel below it arrives; a row of flush transactions
// releases the bottom row and marks its last pixel with end_of_frame. Every
// transaction first reads the middle line store at its column and the one
// to its right and the upper line store at its column, then is decided and
// writes its column back, so the rate of one pixel per clock is set by the
// single write port of each line store. The result register lets a new pixel
// in while a result waits; input stalls only while that register is full and
// not taken. The line stores need no clearing after reset.
module char_image_cross_dilation_unit import cid_pkg::*; #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  cid_in_t               in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output cid_out_t              out_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int CW = $clog2(MAX_WIDTH);

  logic             mode_r;
  logic [PIX_W-1:0] target_r;
  logic [PIX_W-1:0] replace_r;
  logic [FW_W-1:0]  width_r;

  logic             s1_go;
  logic             rd_en;
  logic [CW-1:0]    rd_col, rd_next, s1_col;
  logic             s1_valid;
  cid_s1_t          s1_info;
  cid_nbr_t         nbr;
  cid_wr_t          wr;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= RST_MODE;
      target_r  <= RST_TARGET;
      replace_r <= RST_REPLACE;
      width_r   <= RST_WIDTH;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_addr))
        CFG_MODE:    mode_r    <= cfg_wdata[0];
        CFG_TARGET:  target_r  <= cfg_wdata[PIX_W-1:0];
        CFG_REPLACE: replace_r <= cfg_wdata[PIX_W-1:0];
        CFG_WIDTH:   width_r   <= cfg_wdata[FW_W-1:0];
        default: ;
      endcase
    end
  end

  cid_scan #(.MAX_WIDTH(MAX_WIDTH)) u_scan (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .frame_width (width_r),
    .s1_go       (s1_go),
    .rd_en       (rd_en),
    .rd_col      (rd_col),
    .rd_next     (rd_next),
    .s1_valid    (s1_valid),
    .s1_info     (s1_info),
    .s1_col      (s1_col)
  );

  cid_line_store #(.MAX_WIDTH(MAX_WIDTH)) u_store (
    .clk     (clk),
    .rd_en   (rd_en),
    .rd_col  (rd_col),
    .rd_next (rd_next),
    .wr      (wr),
    .wr_col  (s1_col),
    .nbr     (nbr)
  );

  cid_eval u_eval (
    .clk          (clk),
    .rst_n        (rst_n),
    .s1_valid     (s1_valid),
    .s1_info      (s1_info),
    .nbr          (nbr),
    .mode         (mode_r),
    .target_char  (target_r),
    .replace_char (replace_r),
    .out_ready    (out_ready),
    .s1_go        (s1_go),
    .wr           (wr),
    .out_valid    (out_valid),
    .out_data     (out_data)
  );

endmodule

// File: sv/cid_port_checker.sv
// ----------------------------------------------------------------------------
// cid_port_checker
// Port level checks of the character image cross dilation unit.
// ----------------------------------------------------------------------------
module cid_port_checker import cid_pkg::*; (
  input logic     clk,
  input logic     rst_n,
  input logic     in_valid,
  input logic     in_ready,
  input logic     out_valid,
  input logic     out_ready,
  input cid_out_t out_data
);

  // A result waiting on the output holds until its transaction completes.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed or vanished while stalled");

  // Reset leaves no result pending.
  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result pending after reset");

  // Input is only held off by a result that is stalled.
  a_ready_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled without output back-pressure");

  // A fresh result rises only after an accepted input transaction.
  a_out_latency: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && in_ready, 2))
    else $error("result appeared without a matching input transaction");

endmodule

bind char_image_cross_dilation_unit cid_port_checker u_port_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
